// File: sv/sha1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha1_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_FIN   = 2'd1,
    OP_OVFL  = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } op_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    if (t < 7'd20)      r = (b & c) | (~b & d);
    else if (t < 7'd40) r = b ^ c ^ d;
    else if (t < 7'd60) r = (b & c) | (b & d) | (c & d);
    else                r = b ^ c ^ d;
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] r;
    if (t < 7'd20)      r = 32'h5A827999;
    else if (t < 7'd40) r = 32'h6ED9EBA1;
    else if (t < 7'd60) r = 32'h8F1BBCDC;
    else                r = 32'hCA62C1D6;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/sha1_stream_hasher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// SHA-1 hasher fed one byte per beat. A four-entry queue takes bytes while the
// round engine works; the engine takes one byte per cycle while idle and no
// overflow beat is pending, and each full block then stalls it through the
// load, the rounds and the fold before it takes the next byte. A finish beat
// pads, compresses one or two blocks, then yields five digest words (H0
// first, last one marked). A byte that would wrap the 64-bit bit count is
// dropped and yields a single beat with length_overflow set.
module sha1_stream_hasher_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        command,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word,
  output logic             length_overflow
);
  import sha1_pkg::*;

  op_beat_t q_beat;
  logic     q_valid, q_take;

  sha1_front u_front (
    .clk, .rst, .push, .full, .command, .data_byte,
    .q_beat, .q_valid, .q_take
  );

  sha1_core u_core (
    .clk, .rst, .q_beat, .q_valid, .q_take, .empty, .pop,
    .digest_word, .word_index, .last_word, .length_overflow
  );

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    !empty && last_word |-> word_index == 3'd4) else $error("last without index 4");
  a_ovfl_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && length_overflow |-> digest_word == 32'd0 && !last_word)
    else $error("overflow beat carries digest");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("take from empty queue");
endmodule
`default_nettype wire

// File: sv/sha1_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               command,
  input  wire logic [7:0]         data_byte,
  output sha1_pkg::op_beat_t      q_beat,
  output logic                    q_valid,
  input  wire logic               q_take
);
  import sha1_pkg::*;

  op_beat_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]  count;
  logic [60:0]      byte_count;
  logic             accept;
  logic             do_pop;
  op_beat_t         beat_in;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign accept  = push && !full;
  assign q_valid = (count != '0);
  assign do_pop  = q_take && q_valid;
  assign q_beat  = mem[rptr];

  always_comb begin
    beat_in.data = data_byte;
    if (command == CMD_FINISH)   beat_in.op = OP_FIN;
    else if (&byte_count)        beat_in.op = OP_OVFL;
    else                         beat_in.op = OP_BYTE;
  end

  always_ff @(posedge clk) begin
    if (accept) mem[wptr] <= beat_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
      byte_count <= '0;
    end else begin
      if (accept) begin
        wptr <= wptr + 1'b1;
        if (beat_in.op == OP_FIN)       byte_count <= '0;
        else if (beat_in.op == OP_BYTE) byte_count <= byte_count + 1'b1;
      end
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(accept) - (QPTR_W+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

// File: sv/sha1_core.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  sha1_pkg::op_beat_t      q_beat,
  input  wire logic               q_valid,
  output logic                    q_take,
  output logic                    empty,
  input  wire logic               pop,
  output logic [31:0]             digest_word,
  output logic [2:0]              word_index,
  output logic                    last_word,
  output logic                    length_overflow
);
  import sha1_pkg::*;

  state_t       state, state_next;
  logic [31:0]  h [5];
  logic [31:0]  blk [16];
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e;
  logic [5:0]   nbytes;
  logic [60:0]  nbits;
  logic [6:0]   t;
  logic         fin, second;
  logic         ovfl_pend;
  logic [2:0]   oidx;
  logic [31:0]  wt, tmp, wx;
  logic [3:0]   ti;
  logic         pad_two;

  assign ti = t[3:0];
  assign wx = w[ti+4'd13] ^ w[ti+4'd8] ^ w[ti+4'd2] ^ w[ti];
  assign wt = (t < 7'd16) ? w[ti] : {wx[30:0], wx[31]};
  assign tmp = {a[26:0], a[31:27]} + round_f(t, b, c, d) + e + round_k(t) + wt;
  assign pad_two = (nbytes >= 6'd56);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && !ovfl_pend) begin
          if (q_beat.op == OP_FIN) state_next = ST_PAD;
          else if (q_beat.op == OP_BYTE && nbytes == 6'd63) state_next = ST_LOAD;
        end
      end
      ST_PAD:   state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (t == 7'd79) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!fin)         state_next = ST_IDLE;
        else if (second)  state_next = ST_PAD;
        else              state_next = ST_EMIT;
      end
      ST_EMIT:  if (pop && oidx == 3'd4) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_take = 1'b0;
    empty  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        empty  = !ovfl_pend;
        q_take = q_valid && !ovfl_pend;
      end
      ST_EMIT: empty = 1'b0;
      default: ;
    endcase
  end

  assign digest_word     = (state == ST_EMIT) ? h[oidx] : 32'd0;
  assign word_index      = (state == ST_EMIT) ? oidx : 3'd0;
  assign last_word       = (state == ST_EMIT) && (oidx == 3'd4);
  assign length_overflow = (state != ST_EMIT);

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_take && q_beat.op == OP_BYTE)
          blk[nbytes[5:2]][8*(3-nbytes[1:0]) +: 8] <= q_beat.data;
      end
      ST_PAD: begin
        if (!second) begin
          for (int i = 0; i < 64; i++) begin
            if (i == nbytes) blk[i/4][8*(3-i%4) +: 8] <= PAD_MARK;
            else if (i > nbytes && (pad_two || i < 56)) blk[i/4][8*(3-i%4) +: 8] <= 8'd0;
          end
        end else begin
          for (int i = 0; i < 14; i++) blk[i] <= 32'd0;
        end
        if (!pad_two || second) begin
          blk[14] <= {nbits[60:29]};
          blk[15] <= {nbits[28:0], 3'd0};
        end
      end
      ST_LOAD: begin
        for (int i = 0; i < 16; i++) w[i] <= blk[i];
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
      end
      ST_ROUND: begin
        w[ti] <= wt;
        e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
      nbytes <= '0; nbits <= '0; t <= '0; fin <= 1'b0; second <= 1'b0;
      ovfl_pend <= 1'b0; oidx <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (ovfl_pend && pop) ovfl_pend <= 1'b0;
          if (q_take) begin
            unique case (q_beat.op)
              OP_BYTE: begin nbytes <= nbytes + 1'b1; nbits <= nbits + 1'b1; end
              OP_FIN:  begin fin <= 1'b1; second <= 1'b0; end
              OP_OVFL: ovfl_pend <= 1'b1;
              default: ;
            endcase
          end
        end
        ST_PAD:  second <= pad_two && !second;
        ST_LOAD: t <= '0;
        ST_ROUND: t <= t + 1'b1;
        ST_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          oidx <= '0;
        end
        ST_EMIT: begin
          if (pop) begin
            oidx <= oidx + 1'b1;
            if (oidx == 3'd4) begin
              h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
              nbytes <= '0; nbits <= '0; fin <= 1'b0; second <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
